[hw/rtl/assert_macros.svh]
// Assertion helpers; expect clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/idaj_pkg.sv]
`default_nettype none
package idaj_pkg;

  typedef enum logic [3:0] {
    OP_UPDATE         = 4'd0,
    OP_IN             = 4'd1,
    OP_MID_IN         = 4'd2,
    OP_OUT            = 4'd3,
    OP_SCORE          = 4'd4,
    OP_SCORE_MID      = 4'd5,
    OP_SCORE_MID_SLOW = 4'd6,
    OP_SCORE_BOTTOM   = 4'd7,
    OP_STOP           = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    REG_INTAKE_SPEED = 2'd0,
    REG_SPINUP_MS    = 2'd1,
    REG_REVERSE_MS   = 2'd2,
    REG_STALL_SPEED  = 2'd3
  } reg_e;

  localparam int unsigned ADDR_W = 4;

  typedef struct packed {
    logic [6:0]  intake_speed;
    logic [15:0] spinup_ms;
    logic [15:0] reverse_ms;
    logic [9:0]  stall_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] intake_drive;
    logic              intake_drive_issued;
    logic signed [7:0] hood_drive;
    logic              tray_extended;
    logic              jam_clearing;
  } result_t;

  localparam logic [6:0]  INTAKE_SPEED_RST = 7'd127;
  localparam logic [15:0] SPINUP_MS_RST    = 16'd200;
  localparam logic [15:0] REVERSE_MS_RST   = 16'd80;
  localparam logic [9:0]  STALL_SPEED_RST  = 10'd5;

  localparam logic signed [7:0] FULL_POWER      = 8'sd127;
  localparam logic signed [7:0] REVERSE_POWER   = -8'sd127;
  localparam logic signed [7:0] HOOD_IN         = -8'sd12;
  localparam logic signed [7:0] HOOD_MID_IN     = 8'sd63;
  localparam logic signed [7:0] HOOD_SCORE_MID  = -8'sd88;
  localparam logic signed [7:0] HOOD_SCORE_SLOW = -8'sd52;
  localparam logic signed [7:0] INTAKE_BOTTOM   = -8'sd63;

endpackage
`default_nettype wire

[hw/rtl/intake_drive_anti_jam.sv]
// Intake motor controller with anti-jam reversal.
// Input channel (in_valid/in_ready): one word of op, now_ms, motor_speed.
// Commands (op 1..8) load a drive preset and give no result; op 0 is an
// update that runs the stall check and gives exactly one result word on
// the output channel (out_valid/out_ready). Ops 9..15 are dropped.
// Registers sit behind the APB port at byte addresses 0, 4, 8, 12.
// Flow: a word enters the input register when accepted, and an update's
// result is then loaded into the result register when the input register
// moves on. Throughput: one word per cycle while the output is not stalled, set by the
// single pass of preset decode, two 32-bit time compares and selection
// between the input and result registers.
// When the receiver stalls, the result register holds; the input register
// still drains commands, and a new word is taken whenever the input
// register is empty or moves on in the same cycle.
// Reset clears the valid bits of both registers, all drive state and jam
// tracking, and loads the configuration registers with their defaults.
`default_nettype none
`include "assert_macros.svh"
module intake_drive_anti_jam (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic        [3:0]            op,
  input  wire logic        [31:0]           now_ms,
  input  wire logic signed [10:0]           motor_speed,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [7:0]            intake_drive,
  output logic                              intake_drive_issued,
  output logic signed      [7:0]            hood_drive,
  output logic                              tray_extended,
  output logic                              jam_clearing,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [idaj_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  idaj_pkg::cfg_t    cfg;
  idaj_pkg::result_t result;

  logic               s1_valid;
  logic [3:0]         s1_op;
  logic [31:0]        s1_now;
  logic signed [10:0] s1_speed;
  logic               has_result;
  logic               out_free;
  logic               s1_advance;

  idaj_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  idaj_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (s1_advance),
    .op          (s1_op),
    .now_ms      (s1_now),
    .motor_speed (s1_speed),
    .has_result  (has_result),
    .result      (result)
  );

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && (!has_result || out_free);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op;
      s1_now   <= now_ms;
      s1_speed <= motor_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && has_result) begin
      intake_drive        <= result.intake_drive;
      intake_drive_issued <= result.intake_drive_issued;
      hood_drive          <= result.hood_drive;
      tray_extended       <= result.tray_extended;
      jam_clearing        <= result.jam_clearing;
    end
  end

  `ASSERT_IMPL(a_held_implies_jam, out_valid && !intake_drive_issued, jam_clearing)
  `ASSERT_IMPL(a_jam_drive_reverse, out_valid && jam_clearing && intake_drive_issued,
               intake_drive == idaj_pkg::REVERSE_POWER)
  `ASSERT_NEXT(a_s1_hold, s1_valid && !s1_advance, s1_valid)

endmodule
`default_nettype wire

[hw/rtl/idaj_cfg.sv]
`default_nettype none
module idaj_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [idaj_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output idaj_pkg::cfg_t                    cfg
);

  idaj_pkg::reg_e sel;
  logic           wr_en;

  assign pready = 1'b1;
  assign sel    = idaj_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intake_speed <= idaj_pkg::INTAKE_SPEED_RST;
      cfg.spinup_ms    <= idaj_pkg::SPINUP_MS_RST;
      cfg.reverse_ms   <= idaj_pkg::REVERSE_MS_RST;
      cfg.stall_speed  <= idaj_pkg::STALL_SPEED_RST;
    end else if (wr_en) begin
      unique case (sel)
        idaj_pkg::REG_INTAKE_SPEED: cfg.intake_speed <= pwdata[6:0];
        idaj_pkg::REG_SPINUP_MS:    cfg.spinup_ms    <= pwdata[15:0];
        idaj_pkg::REG_REVERSE_MS:   cfg.reverse_ms   <= pwdata[15:0];
        idaj_pkg::REG_STALL_SPEED:  cfg.stall_speed  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      idaj_pkg::REG_INTAKE_SPEED: prdata = {25'd0, cfg.intake_speed};
      idaj_pkg::REG_SPINUP_MS:    prdata = {16'd0, cfg.spinup_ms};
      idaj_pkg::REG_REVERSE_MS:   prdata = {16'd0, cfg.reverse_ms};
      idaj_pkg::REG_STALL_SPEED:  prdata = {22'd0, cfg.stall_speed};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/idaj_core.sv]
`default_nettype none
module idaj_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire idaj_pkg::cfg_t     cfg,
  input  wire logic               step,
  input  wire logic        [3:0]  op,
  input  wire logic        [31:0] now_ms,
  input  wire logic signed [10:0] motor_speed,
  output logic                    has_result,
  output idaj_pkg::result_t       result
);

  logic signed [7:0] intake_power;
  logic signed [7:0] hood_power;
  logic              tray_out;
  logic [31:0]       command_time;
  logic              jam_active;
  logic [31:0]       jam_start;

  logic              is_cmd;
  logic              stamp;
  logic signed [7:0] intake_power_next;
  logic signed [7:0] hood_power_next;
  logic              tray_out_next;
  logic              jam_active_next;
  logic [31:0]       jam_start_next;

  logic signed [7:0] spd;
  logic [10:0]       speed_mag;
  logic [31:0]       since_cmd;
  logic [31:0]       since_jam;
  logic              check;
  logic              jam_expired;
  logic              stalled;
  logic              reversed;

  assign spd = {1'b0, cfg.intake_speed};

  // Decode the preset table.
  always_comb begin
    is_cmd            = 1'b1;
    stamp             = 1'b1;
    has_result        = 1'b0;
    intake_power_next = intake_power;
    hood_power_next   = hood_power;
    tray_out_next     = tray_out;
    unique case (idaj_pkg::op_e'(op))
      idaj_pkg::OP_UPDATE: begin
        is_cmd     = 1'b0;
        stamp      = 1'b0;
        has_result = 1'b1;
      end
      idaj_pkg::OP_IN: begin
        intake_power_next = spd;
        hood_power_next   = idaj_pkg::HOOD_IN;
        tray_out_next     = 1'b0;
      end
      idaj_pkg::OP_MID_IN: begin
        intake_power_next = 8'sd0;
        hood_power_next   = idaj_pkg::HOOD_MID_IN;
        tray_out_next     = 1'b1;
      end
      idaj_pkg::OP_OUT: begin
        intake_power_next = -spd;
        hood_power_next   = 8'sd0;
        tray_out_next     = 1'b0;
      end
      idaj_pkg::OP_SCORE: begin
        intake_power_next = idaj_pkg::FULL_POWER;
        hood_power_next   = idaj_pkg::FULL_POWER;
        tray_out_next     = 1'b0;
      end
      idaj_pkg::OP_SCORE_MID: begin
        intake_power_next = idaj_pkg::FULL_POWER;
        hood_power_next   = idaj_pkg::HOOD_SCORE_MID;
        tray_out_next     = 1'b1;
      end
      idaj_pkg::OP_SCORE_MID_SLOW: begin
        intake_power_next = idaj_pkg::FULL_POWER;
        hood_power_next   = idaj_pkg::HOOD_SCORE_SLOW;
        tray_out_next     = 1'b1;
      end
      idaj_pkg::OP_SCORE_BOTTOM: begin
        intake_power_next = idaj_pkg::INTAKE_BOTTOM;
        hood_power_next   = 8'sd0;
        tray_out_next     = 1'b0;
      end
      idaj_pkg::OP_STOP: begin
        intake_power_next = 8'sd0;
        hood_power_next   = 8'sd0;
        tray_out_next     = 1'b0;
        stamp             = 1'b0;
      end
      default: begin
        is_cmd = 1'b0;
        stamp  = 1'b0;
      end
    endcase
  end

  // Magnitude of -1024 is 1024, which still fits as unsigned.
  assign speed_mag   = motor_speed[10] ? 11'(-motor_speed) : 11'(motor_speed);
  assign since_cmd   = now_ms - command_time;
  assign since_jam   = now_ms - jam_start;
  assign check       = !intake_power[7] && (intake_power != 8'sd0) &&
                       (since_cmd >= {16'd0, cfg.spinup_ms});
  assign jam_expired = since_jam > {16'd0, cfg.reverse_ms};
  assign stalled     = speed_mag < {1'b0, cfg.stall_speed};

  always_comb begin
    jam_active_next = jam_active;
    jam_start_next  = jam_start;
    reversed        = 1'b0;
    if (check) begin
      if (jam_active && !jam_expired) begin
        reversed = 1'b1;
      end else begin
        jam_active_next = 1'b0;
        if (stalled) begin
          jam_active_next = 1'b1;
          jam_start_next  = now_ms;
          reversed        = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.hood_drive    = hood_power;
    result.tray_extended = tray_out;
    result.jam_clearing  = jam_active_next;
    priority if (reversed) begin
      result.intake_drive        = idaj_pkg::REVERSE_POWER;
      result.intake_drive_issued = 1'b1;
    end else if (!jam_active_next) begin
      result.intake_drive        = intake_power;
      result.intake_drive_issued = 1'b1;
    end else begin
      // Jam still pending but check skipped: hold the motor output.
      result.intake_drive        = 8'sd0;
      result.intake_drive_issued = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intake_power <= 8'sd0;
      hood_power   <= 8'sd0;
      tray_out     <= 1'b0;
      command_time <= 32'd0;
      jam_active   <= 1'b0;
      jam_start    <= 32'd0;
    end else if (step) begin
      if (is_cmd) begin
        intake_power <= intake_power_next;
        hood_power   <= hood_power_next;
        tray_out     <= tray_out_next;
      end
      if (stamp) begin
        command_time <= now_ms;
      end
      if (has_result) begin
        jam_active <= jam_active_next;
        jam_start  <= jam_start_next;
      end
    end
  end

endmodule
`default_nettype wire
